[rtl/core/box_filter_downsampler_macros.svh]
// Assertion macros shared by the box filter downsampler modules.
// Each use ends with its own semicolon, so a use stands alone on its line.
`ifndef BOX_FILTER_DOWNSAMPLER_MACROS_SVH
`define BOX_FILTER_DOWNSAMPLER_MACROS_SVH
`ifndef SYNTHESIS
`define BFD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("box filter downsampler: assertion failed");
`define BFD_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("box filter downsampler: reset assertion failed");
`else
`define BFD_ASSERT(lbl, clk, rst_n, prop)
`define BFD_ASSERT_RST(lbl, clk, prop)
`endif
`endif

[rtl/core/bfd_pkg.sv]
package bfd_pkg;

    localparam int MAX_SUPERSAMPLE   = 4;
    localparam int SS_W              = $clog2(MAX_SUPERSAMPLE);
    localparam int HEIGHT_CAP        = 1024;
    localparam int ROW_W             = $clog2(HEIGHT_CAP);
    localparam int DEF_MAX_OUT_WIDTH = 1024;

    localparam int PIX_W       = 16;
    localparam int ACC_W       = 20;
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int SS_FIELD_W  = 3;
    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 24;
    localparam int PROD_W      = ACC_W + RECIP_W;
    localparam int S_DATA_W    = 4 * PIX_W;
    localparam int M_DATA_W    = 72;

    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUPERSAMPLE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_SCALE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic accum;
        logic scale;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic block_done;
        logic out_free;
    } dp_status_t;

    // Reciprocal of the block area, scaled by 2**RECIP_SHIFT and rounded up.
    // For sums below 2**20 the product shifted right gives the exact floor.
    function automatic logic [RECIP_W-1:0] area_recip(input logic [SS_W-1:0] ss_last);
        logic [RECIP_W-1:0] r;
        case (ss_last)
            2'd0:    r = 25'd16777216;
            2'd1:    r = 25'd4194304;
            2'd2:    r = 25'd1864136;
            2'd3:    r = 25'd1048576;
            default: r = 25'd16777216;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/bfd_ctrl.sv]
`include "box_filter_downsampler_macros.svh"

module bfd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  bfd_pkg::dp_status_t status,
    output bfd_pkg::dp_cmd_t    cmd
);
    import bfd_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                state_next = status.block_done ? ST_SCALE : ST_IDLE;
            end
            ST_SCALE: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_ACCUM: begin
                cmd.accum = 1'b1;
            end
            ST_SCALE: begin
                cmd.scale = 1'b1;
            end
            ST_EMIT: begin
                cmd.emit = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // Every accumulate step belongs to a beat taken in the cycle before.
    `BFD_ASSERT(a_accum_after_beat, aclk, aresetn, cmd.accum |-> $past(s_tvalid && s_tready))
    `BFD_ASSERT(a_one_cmd, aclk, aresetn, $onehot0(cmd))

endmodule

[rtl/core/bfd_datapath.sv]
`include "box_filter_downsampler_macros.svh"

module bfd_datapath #(
    parameter int MAX_OUT_WIDTH = bfd_pkg::DEF_MAX_OUT_WIDTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              restart,
    input  logic [$clog2(MAX_OUT_WIDTH)-1:0]  w_last,
    input  logic [bfd_pkg::ROW_W-1:0]         h_last,
    input  logic [bfd_pkg::SS_W-1:0]          ss_last,
    input  logic [bfd_pkg::S_DATA_W-1:0]      s_tdata,
    input  bfd_pkg::dp_cmd_t                  cmd,
    output bfd_pkg::dp_status_t               status,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bfd_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                              m_tlast
);
    import bfd_pkg::*;

    localparam int COL_W  = $clog2(MAX_OUT_WIDTH);
    localparam int WORD_W = 4 * ACC_W;
    localparam int PAD_W  = M_DATA_W - ACC_W - 3 * PIX_W;

    logic [WORD_W-1:0]   acc_mem [MAX_OUT_WIDTH];
    logic [WORD_W-1:0]   rd_reg;
    logic [S_DATA_W-1:0] pix_reg;

    logic [SS_W-1:0]  sub_col_reg, sub_col_next;
    logic [SS_W-1:0]  sub_row_reg, sub_row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic             first_px;
    logic             block_done;
    logic             frame_done;
    logic [ACC_W-1:0] sum [4];
    logic [ACC_W-1:0] sum_reg [4];
    logic             frame_reg;
    logic [ACC_W-1:0] isum_reg;
    logic [PROD_W-1:0] prod_reg [3];

    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic                m_tlast_reg;

    assign first_px   = (sub_col_reg == '0) && (sub_row_reg == '0);
    assign block_done = (sub_col_reg == ss_last) && (sub_row_reg == ss_last);
    assign frame_done = block_done && (col_reg == w_last) && (row_reg == h_last);

    assign status.block_done = block_done;
    assign status.out_free   = !m_tvalid_reg || m_tready;

    // The first pixel of a block starts from zero, so a stored word of a
    // column that this frame has not yet written is never used.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            sum[k] = (first_px ? '0 : rd_reg[k*ACC_W +: ACC_W])
                   + ACC_W'(pix_reg[k*PIX_W +: PIX_W]);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accum && !block_done) begin
            acc_mem[col_reg] <= {sum[3], sum[2], sum[1], sum[0]};
        end
        if (cmd.load) begin
            rd_reg  <= acc_mem[col_reg];
            pix_reg <= s_tdata;
        end
    end

    always_comb begin
        sub_col_next = sub_col_reg;
        sub_row_next = sub_row_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        if (sub_col_reg == ss_last) begin
            sub_col_next = '0;
            if (col_reg == w_last) begin
                col_next = '0;
                if (sub_row_reg == ss_last) begin
                    sub_row_next = '0;
                    row_next     = (row_reg == h_last) ? '0 : row_reg + 1'b1;
                end else begin
                    sub_row_next = sub_row_reg + 1'b1;
                end
            end else begin
                col_next = col_reg + 1'b1;
            end
        end else begin
            sub_col_next = sub_col_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            sub_col_reg <= '0;
            sub_row_reg <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
        end else if (cmd.accum) begin
            sub_col_reg <= sub_col_next;
            sub_row_reg <= sub_row_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accum && block_done) begin
            sum_reg   <= sum;
            frame_reg <= frame_done;
        end
        if (cmd.scale) begin
            isum_reg <= sum_reg[0];
            for (int k = 0; k < 3; k++) begin
                prod_reg[k] <= PROD_W'(sum_reg[k+1]) * PROD_W'(area_recip(ss_last));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= {{PAD_W{1'b0}},
                            prod_reg[2][RECIP_SHIFT +: PIX_W],
                            prod_reg[1][RECIP_SHIFT +: PIX_W],
                            prod_reg[0][RECIP_SHIFT +: PIX_W],
                            isum_reg};
            m_tlast_reg <= frame_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `BFD_ASSERT(a_pos_in_range, aclk, aresetn, (col_reg <= w_last) && (row_reg <= h_last) && (sub_col_reg <= ss_last) && (sub_row_reg <= ss_last))
    `BFD_ASSERT(a_frame_wraps, aclk, aresetn, (cmd.accum && frame_done && !restart) |=> (col_reg == '0) && (row_reg == '0) && (sub_col_reg == '0) && (sub_row_reg == '0))
    `BFD_ASSERT(a_no_overwrite, aclk, aresetn, cmd.emit |-> (!m_tvalid_reg || m_tready))

endmodule

[rtl/core/box_filter_downsampler.sv]
// Box filter downsampler for a supersampled image.
// Slave channel: one supersampled pixel per beat in raster order, the image
// being out_width*supersample pixels wide and out_height*supersample rows.
// Master channel: one averaged pixel per supersample-by-supersample block,
// in raster order; tlast marks the last pixel of each output frame.
// Configuration: cfg_we writes register cfg_index (0 width, 1 height,
// 2 supersample); any valid write restarts the frame at its first pixel.
// Each beat passes through the read-modify-write of the column accumulator
// memory (a read step, then an add and write-back step), and no new beat is
// taken until the write-back is done. A beat that completes a block then
// takes a reciprocal multiply step and a step to load the output register,
// which waits while the previous result has not been taken.
// If the receiver stalls, the result waits in the output register and the
// block keeps taking beats; it holds only when a second result is ready
// while the first has not been taken.
// Reset returns the registers to 256 x 256 (width capped at MAX_OUT_WIDTH)
// with no supersampling and starts a new frame. No clearing pass is needed:
// the first pixel of every block ignores the stored accumulator word.
`include "box_filter_downsampler_macros.svh"

module box_filter_downsampler #(
    parameter int MAX_OUT_WIDTH = bfd_pkg::DEF_MAX_OUT_WIDTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // intensity [15:0], red [31:16], green [47:32], blue [63:48]
    input  logic [bfd_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // intensity_sum [19:0], red_avg [35:20], green_avg [51:36],
    // blue_avg [67:52], zero [71:68]
    output logic [bfd_pkg::M_DATA_W-1:0]    m_tdata,
    output logic                            m_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_we,
    input  logic [bfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bfd_pkg::CFG_W-1:0]       cfg_wdata
);
    import bfd_pkg::*;

    localparam int COL_W = $clog2(MAX_OUT_WIDTH);

    logic [COL_W-1:0]      w_last_reg;
    logic [ROW_W-1:0]      h_last_reg;
    logic [SS_W-1:0]       ss_last_reg;
    logic [SS_FIELD_W-1:0] ss_field;
    logic                  restart;
    dp_cmd_t               cmd;
    dp_status_t            status;

    assign ss_field = cfg_wdata[SS_FIELD_W-1:0];

    always_comb begin
        case (cfg_index)
            CFG_OUT_WIDTH, CFG_OUT_HEIGHT, CFG_SUPERSAMPLE: restart = cfg_we;
            default:                                        restart = 1'b0;
        endcase
    end

    // Registers hold the saturated value minus one, ready for the counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_last_reg  <= (MAX_OUT_WIDTH < 256) ? COL_W'(MAX_OUT_WIDTH - 1) : COL_W'(255);
            h_last_reg  <= ROW_W'(255);
            ss_last_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_OUT_WIDTH: begin
                    if (cfg_wdata == '0) begin
                        w_last_reg <= '0;
                    end else if (32'(cfg_wdata) > MAX_OUT_WIDTH) begin
                        w_last_reg <= COL_W'(MAX_OUT_WIDTH - 1);
                    end else begin
                        w_last_reg <= COL_W'(cfg_wdata - 1'b1);
                    end
                end
                CFG_OUT_HEIGHT: begin
                    if (cfg_wdata == '0) begin
                        h_last_reg <= '0;
                    end else if (32'(cfg_wdata) > HEIGHT_CAP) begin
                        h_last_reg <= ROW_W'(HEIGHT_CAP - 1);
                    end else begin
                        h_last_reg <= ROW_W'(cfg_wdata - 1'b1);
                    end
                end
                CFG_SUPERSAMPLE: begin
                    if (ss_field == '0) begin
                        ss_last_reg <= '0;
                    end else if (32'(ss_field) > MAX_SUPERSAMPLE) begin
                        ss_last_reg <= SS_W'(MAX_SUPERSAMPLE - 1);
                    end else begin
                        ss_last_reg <= SS_W'(ss_field - 1'b1);
                    end
                end
                default: begin
                    ss_last_reg <= ss_last_reg;
                end
            endcase
        end
    end

    bfd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bfd_datapath #(
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .restart  (restart),
        .w_last   (w_last_reg),
        .h_last   (h_last_reg),
        .ss_last  (ss_last_reg),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    `BFD_ASSERT_RST(a_reset_clean, aclk, !aresetn |=> !m_tvalid && s_tready)
    `BFD_ASSERT(a_pad_zero, aclk, aresetn, m_tvalid |-> (m_tdata[M_DATA_W-1:M_DATA_W-4] == '0))

endmodule
